// File: design/string_table_with_sort_core_assert.svh
// Assertion macros for the string table core.
// Each macro reports through $error and is switched off as a whole by NO_ASSERTIONS.
`ifndef STRING_TABLE_WITH_SORT_CORE_ASSERT_SVH
`define STRING_TABLE_WITH_SORT_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define STWS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define STWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STWS_ASSERT(lbl, clk, rstn, prop, msg)
`define STWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/stws_pkg.sv
`timescale 1ns / 1ps

package stws_pkg;

    // Table dimensions; the field widths of the stream beats are sized for these.
    localparam int MAX_ENTRIES = 16;
    localparam int MAX_CHARS   = 20;

    // Fixed field widths of the stream beats.
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Operation selector carried in the input tuser.
    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SORT   = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // One input item.
    typedef struct packed {
        t_func               func;
        logic [CHAR_W-1:0]   char_in;
        logic                end_of_string;
        logic [INDEX_W-1:0]  entry_index;
        logic [POS_W-1:0]    char_pos;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [CHAR_W-1:0]   char_out;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_AP,
        S_RD_SLOT,
        S_RD_CHAR,
        S_DL_SAVE,
        S_DL_MOVE,
        S_DL_LAST,
        S_SO_RA,
        S_SO_RB,
        S_SO_LA,
        S_SO_LB,
        S_SO_LEN,
        S_SO_CA,
        S_SO_CB,
        S_SO_CC,
        S_SO_DEC,
        S_SO_SW,
        S_RSP
    } t_state;

endpackage

// File: design/stws_ram.sv
`timescale 1ns / 1ps

module stws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/stws_ctrl.sv
`timescale 1ns / 1ps
`include "string_table_with_sort_core_assert.svh"

module stws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  stws_pkg::t_item i_item,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output stws_pkg::t_rsp o_rsp
);

    localparam int MAX_ENTRIES = stws_pkg::MAX_ENTRIES;
    localparam int MAX_CHARS   = stws_pkg::MAX_CHARS;

    // One spare slot holds the staging string when the table is full.
    localparam int NSLOT = MAX_ENTRIES + 1;
    localparam int SW    = $clog2(NSLOT);
    localparam int LW    = $clog2(MAX_CHARS + 1);
    localparam int PW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int CD    = NSLOT * MAX_CHARS;
    localparam int AW    = $clog2(CD);
    localparam int KW    = ((SW > stws_pkg::INDEX_W) ? SW : stws_pkg::INDEX_W) + 1;
    localparam int XW    = ((LW > stws_pkg::POS_W) ? LW : stws_pkg::POS_W) + 1;

    // Character address of a byte within a slot.
    function automatic logic [AW-1:0] char_addr(input logic [SW-1:0] slot,
                                                input logic [PW-1:0] off);
        return AW'(slot) * AW'(MAX_CHARS) + AW'(off);
    endfunction

    stws_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_count, n_count;
    logic [LW-1:0]    r_len, n_len;
    logic [SW-1:0]    r_i, n_i;
    logic [SW-1:0]    r_d, n_d;
    logic [SW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_j, n_j;
    logic [SW-1:0]    r_sa, n_sa;
    logic [SW-1:0]    r_sb, n_sb;
    logic [LW-1:0]    r_la, n_la;
    logic [LW-1:0]    r_lb, n_lb;
    logic [LW-1:0]    r_k, n_k;
    logic [7:0]       r_ca, n_ca;
    logic             r_gt, n_gt;
    stws_pkg::t_item  r_item, n_item;
    logic [7:0]       r_char, n_char;
    logic [stws_pkg::STATUS_W-1:0] r_status, n_status;

    // Memory ports: slot order, slot lengths, characters.
    logic            ord_we, ord_re;
    logic [SW-1:0]   ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic            len_we, len_re;
    logic [SW-1:0]   len_waddr, len_raddr;
    logic [LW-1:0]   len_wdata, len_rdata;
    logic            chr_we, chr_re;
    logic [AW-1:0]   chr_waddr, chr_raddr;
    logic [7:0]      chr_rdata;

    logic [SW-1:0]   w_in_idx_m1, w_idx_m1;
    logic            w_in_bad;
    logic            w_pos_ok;
    logic [LW-1:0]   w_len_inc;
    logic [LW-1:0]   w_min;
    logic            w_more_j, w_more_p;

    // The order memory maps entry number to slot; entry count is the staging slot.
    stws_ram #(.WIDTH(SW), .DEPTH(NSLOT)) u_ord_ram (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_re(ord_re), .i_raddr(ord_raddr), .o_rdata(ord_rdata)
    );

    stws_ram #(.WIDTH(LW), .DEPTH(NSLOT)) u_len_ram (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_re(len_re), .i_raddr(len_raddr), .o_rdata(len_rdata)
    );

    stws_ram #(.WIDTH(8), .DEPTH(CD)) u_chr_ram (
        .i_clk(i_clk), .i_we(chr_we), .i_waddr(chr_waddr), .i_wdata(r_item.char_in),
        .i_re(chr_re), .i_raddr(chr_raddr), .o_rdata(chr_rdata)
    );

    // Index checks and small arithmetic shared by the states.
    assign w_in_bad    = (i_item.entry_index == '0) ||
                         (KW'(i_item.entry_index) > KW'(r_count));
    assign w_in_idx_m1 = SW'(KW'(i_item.entry_index) - KW'(1));
    assign w_idx_m1    = SW'(KW'(r_item.entry_index) - KW'(1));
    assign w_pos_ok    = XW'(r_item.char_pos) < XW'(MAX_CHARS);
    assign w_len_inc   = (r_len < LW'(MAX_CHARS)) ? LW'(r_len + LW'(1)) : r_len;
    assign w_min       = (r_la < r_lb) ? r_la : r_lb;
    assign w_more_j    = (KW'(r_j) + KW'(r_p) + KW'(2)) < KW'(r_count);
    assign w_more_p    = (KW'(r_p) + KW'(2)) < KW'(r_count);

    // State and data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stws_pkg::S_INIT;
            r_count <= '0;
            r_len   <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_len   <= n_len;
            r_i     <= n_i;
        end
        r_d      <= n_d;
        r_p      <= n_p;
        r_j      <= n_j;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_la     <= n_la;
        r_lb     <= n_lb;
        r_k      <= n_k;
        r_ca     <= n_ca;
        r_gt     <= n_gt;
        r_item   <= n_item;
        r_char   <= n_char;
        r_status <= n_status;
    end

    // Sequencer: next state, memory accesses and handshakes.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_len    = r_len;
        n_i      = r_i;
        n_d      = r_d;
        n_p      = r_p;
        n_j      = r_j;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_la     = r_la;
        n_lb     = r_lb;
        n_k      = r_k;
        n_ca     = r_ca;
        n_gt     = r_gt;
        n_item   = r_item;
        n_char   = r_char;
        n_status = r_status;

        ord_we    = 1'b0;
        ord_waddr = r_i;
        ord_wdata = r_i;
        ord_re    = 1'b0;
        ord_raddr = r_count;
        len_we    = 1'b0;
        len_waddr = ord_rdata;
        len_wdata = w_len_inc;
        len_re    = 1'b0;
        len_raddr = r_sa;
        chr_we    = 1'b0;
        chr_waddr = char_addr(ord_rdata, PW'(r_len));
        chr_re    = 1'b0;
        chr_raddr = char_addr(r_sa, PW'(r_k));

        o_item_ready = 1'b0;
        o_rsp_valid  = 1'b0;

        unique case (r_state)
            // Fill the order memory with the identity permutation.
            stws_pkg::S_INIT: begin
                ord_we    = 1'b1;
                ord_waddr = r_i;
                ord_wdata = r_i;
                if (r_i == SW'(MAX_ENTRIES)) begin
                    n_i     = '0;
                    n_state = stws_pkg::S_IDLE;
                end else begin
                    n_i = SW'(r_i + SW'(1));
                end
            end

            stws_pkg::S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_item   = i_item;
                    n_status = stws_pkg::STATUS_OK;
                    n_char   = '0;
                    unique case (i_item.func)
                        stws_pkg::FUNC_APPEND: begin
                            ord_re    = 1'b1;
                            ord_raddr = r_count;
                            n_state   = stws_pkg::S_AP;
                        end
                        stws_pkg::FUNC_DELETE: begin
                            if (w_in_bad) begin
                                n_status = stws_pkg::STATUS_RANGE;
                                n_state  = stws_pkg::S_RSP;
                            end else begin
                                ord_re    = 1'b1;
                                ord_raddr = w_in_idx_m1;
                                n_state   = stws_pkg::S_DL_SAVE;
                            end
                        end
                        stws_pkg::FUNC_SORT: begin
                            n_p = '0;
                            n_j = '0;
                            if (r_count < SW'(2)) begin
                                n_state = stws_pkg::S_RSP;
                            end else begin
                                n_state = stws_pkg::S_SO_RA;
                            end
                        end
                        stws_pkg::FUNC_READ: begin
                            if (w_in_bad) begin
                                n_status = stws_pkg::STATUS_RANGE;
                                n_state  = stws_pkg::S_RSP;
                            end else begin
                                ord_re    = 1'b1;
                                ord_raddr = w_in_idx_m1;
                                n_state   = stws_pkg::S_RD_SLOT;
                            end
                        end
                    endcase
                end
            end

            // Append straight into the staging slot; a commit writes the length and bumps the count.
            stws_pkg::S_AP: begin
                if (r_len < LW'(MAX_CHARS)) begin
                    chr_we    = 1'b1;
                    chr_waddr = char_addr(ord_rdata, PW'(r_len));
                end
                n_len = w_len_inc;
                if (r_item.end_of_string) begin
                    if (r_count < SW'(MAX_ENTRIES)) begin
                        len_we    = 1'b1;
                        len_waddr = ord_rdata;
                        len_wdata = w_len_inc;
                        n_count   = SW'(r_count + SW'(1));
                    end else begin
                        n_status = stws_pkg::STATUS_FULL;
                    end
                    n_len = '0;
                end
                n_state = stws_pkg::S_RSP;
            end

            stws_pkg::S_RD_SLOT: begin
                len_re    = 1'b1;
                len_raddr = ord_rdata;
                chr_re    = 1'b1;
                chr_raddr = char_addr(ord_rdata,
                                      w_pos_ok ? PW'(r_item.char_pos) : PW'(0));
                n_state   = stws_pkg::S_RD_CHAR;
            end

            stws_pkg::S_RD_CHAR: begin
                if (w_pos_ok && (XW'(r_item.char_pos) < XW'(len_rdata))) begin
                    n_char = chr_rdata;
                end
                n_state = stws_pkg::S_RSP;
            end

            // Delete rotates the deleted slot past the staging slot to the free end.
            stws_pkg::S_DL_SAVE: begin
                n_d       = ord_rdata;
                n_i       = w_idx_m1;
                ord_re    = 1'b1;
                ord_raddr = SW'(w_idx_m1 + SW'(1));
                n_state   = stws_pkg::S_DL_MOVE;
            end

            stws_pkg::S_DL_MOVE: begin
                ord_we    = 1'b1;
                ord_waddr = r_i;
                ord_wdata = ord_rdata;
                n_i       = SW'(r_i + SW'(1));
                if (KW'(r_i) + KW'(1) < KW'(r_count)) begin
                    ord_re    = 1'b1;
                    ord_raddr = SW'(r_i + SW'(2));
                end else begin
                    n_state = stws_pkg::S_DL_LAST;
                end
            end

            stws_pkg::S_DL_LAST: begin
                ord_we    = 1'b1;
                ord_waddr = r_count;
                ord_wdata = r_d;
                n_count   = SW'(r_count - SW'(1));
                n_state   = stws_pkg::S_RSP;
            end

            // Bubble sort: fetch both slots and lengths of the pair.
            stws_pkg::S_SO_RA: begin
                ord_re    = 1'b1;
                ord_raddr = r_j;
                n_state   = stws_pkg::S_SO_RB;
            end

            stws_pkg::S_SO_RB: begin
                n_sa      = ord_rdata;
                ord_re    = 1'b1;
                ord_raddr = SW'(r_j + SW'(1));
                n_state   = stws_pkg::S_SO_LA;
            end

            stws_pkg::S_SO_LA: begin
                n_sb      = ord_rdata;
                len_re    = 1'b1;
                len_raddr = r_sa;
                n_state   = stws_pkg::S_SO_LB;
            end

            stws_pkg::S_SO_LB: begin
                n_la      = len_rdata;
                len_re    = 1'b1;
                len_raddr = r_sb;
                n_state   = stws_pkg::S_SO_LEN;
            end

            stws_pkg::S_SO_LEN: begin
                n_lb = len_rdata;
                n_k  = '0;
                if ((r_la == '0) || (len_rdata == '0)) begin
                    n_gt    = r_la > len_rdata;
                    n_state = stws_pkg::S_SO_DEC;
                end else begin
                    n_state = stws_pkg::S_SO_CA;
                end
            end

            // Byte compare, one memory read per cycle.
            stws_pkg::S_SO_CA: begin
                chr_re    = 1'b1;
                chr_raddr = char_addr(r_sa, PW'(r_k));
                n_state   = stws_pkg::S_SO_CB;
            end

            stws_pkg::S_SO_CB: begin
                n_ca      = chr_rdata;
                chr_re    = 1'b1;
                chr_raddr = char_addr(r_sb, PW'(r_k));
                n_state   = stws_pkg::S_SO_CC;
            end

            stws_pkg::S_SO_CC: begin
                if (r_ca != chr_rdata) begin
                    n_gt    = r_ca > chr_rdata;
                    n_state = stws_pkg::S_SO_DEC;
                end else if (LW'(r_k + LW'(1)) < w_min) begin
                    n_k     = LW'(r_k + LW'(1));
                    n_state = stws_pkg::S_SO_CA;
                end else begin
                    n_gt    = r_la > r_lb;
                    n_state = stws_pkg::S_SO_DEC;
                end
            end

            stws_pkg::S_SO_DEC: begin
                if (r_gt) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_j;
                    ord_wdata = r_sb;
                    n_state   = stws_pkg::S_SO_SW;
                end else if (w_more_j) begin
                    n_j     = SW'(r_j + SW'(1));
                    n_state = stws_pkg::S_SO_RA;
                end else if (w_more_p) begin
                    n_p     = SW'(r_p + SW'(1));
                    n_j     = '0;
                    n_state = stws_pkg::S_SO_RA;
                end else begin
                    n_state = stws_pkg::S_RSP;
                end
            end

            stws_pkg::S_SO_SW: begin
                ord_we    = 1'b1;
                ord_waddr = SW'(r_j + SW'(1));
                ord_wdata = r_sa;
                if (w_more_j) begin
                    n_j     = SW'(r_j + SW'(1));
                    n_state = stws_pkg::S_SO_RA;
                end else if (w_more_p) begin
                    n_p     = SW'(r_p + SW'(1));
                    n_j     = '0;
                    n_state = stws_pkg::S_SO_RA;
                end else begin
                    n_state = stws_pkg::S_RSP;
                end
            end

            stws_pkg::S_RSP: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_state = stws_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = stws_pkg::S_IDLE;
            end
        endcase
    end

    // Result of the current item.
    always_comb begin
        o_rsp.char_out    = r_char;
        o_rsp.entry_count = stws_pkg::COUNT_W'(r_count);
        o_rsp.status      = r_status;
    end

    `STWS_ASSERT(a_len_bound, i_clk, i_rst_n, r_len <= LW'(MAX_CHARS), "staging length overrun")
    `STWS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= SW'(MAX_ENTRIES), "entry count overrun")
    `STWS_ASSERT_NEXT(a_del_dec, i_clk, i_rst_n, r_state == stws_pkg::S_DL_LAST, r_count == SW'($past(r_count) - SW'(1)), "delete did not drop the count")
    `STWS_ASSERT_NEXT(a_sort_keep, i_clk, i_rst_n, r_state == stws_pkg::S_SO_RA, $stable(r_count) && $stable(r_len), "sort disturbed count or staging")
    `STWS_ASSERT(a_idle_nowr, i_clk, i_rst_n, !((r_state == stws_pkg::S_IDLE) && (ord_we || len_we || chr_we)), "memory write while idle")

endmodule

// File: design/string_table_with_sort_core.sv
`timescale 1ns / 1ps

// String table with sort. Holds up to MAX_ENTRIES byte strings of up to MAX_CHARS bytes
// (both fixed in the package) plus one staging string, all in on-chip memories reached
// through a slot order table, so deletes and sorts move slot numbers rather than
// characters. Items are handled one at a time. A sort is a bubble sort that compares
// each pair byte by byte (the equal leading bytes and the first differing one, up to
// the shorter length) and swaps the pair when it is out of order; the single read port
// of the character memory sets the compare time. After reset a pass initialises the
// order table, during which no item is accepted. A finished result sits in an output
// register, so the next item may be accepted while it waits.
module string_table_with_sort_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_in[7:0], entry_index[12:8], char_pos[17:13]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // char_out[7:0], entry_count[12:8]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    stws_pkg::t_item w_item;
    stws_pkg::t_rsp  w_rsp;
    logic            w_rsp_valid;
    logic            w_rsp_ready;
    logic            r_out_valid;
    stws_pkg::t_rsp  r_out;

    // Unpack the input beat.
    always_comb begin
        w_item.func          = stws_pkg::t_func'(s_axis_tuser);
        w_item.char_in       = s_axis_tdata[7:0];
        w_item.end_of_string = s_axis_tlast;
        w_item.entry_index   = s_axis_tdata[12:8];
        w_item.char_pos      = s_axis_tdata[17:13];
    end

    stws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(s_axis_tvalid),
        .o_item_ready(s_axis_tready),
        .i_item      (w_item),
        .o_rsp_valid (w_rsp_valid),
        .i_rsp_ready (w_rsp_ready),
        .o_rsp       (w_rsp)
    );

    // Output register: loads whenever it is empty or its beat is being taken.
    assign w_rsp_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp_ready) begin
            r_out_valid <= w_rsp_valid;
        end
        if (w_rsp_ready && w_rsp_valid) begin
            r_out <= w_rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.entry_count, r_out.char_out};
    assign m_axis_tuser  = r_out.status;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_ENTRIES = stws_pkg::MAX_ENTRIES;
    localparam int N_CHARS   = stws_pkg::MAX_CHARS;
    localparam int N_RANDOM  = 830;
    localparam int CW        = stws_pkg::COUNT_W;

    // One row of the directed table; known marks an expectation typed in by hand.
    typedef struct {
        stws_pkg::t_item it;
        bit              known;
        stws_pkg::t_rsp  rsp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // char_in[7:0], entry_index[12:8], char_pos[17:13]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        s_axis_tlast;   // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // char_out[7:0], entry_count[12:8]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // Shadow copy of the table and the staging string.
    logic [7:0] shadow_chars [N_ENTRIES][N_CHARS];
    int         shadow_len   [N_ENTRIES];
    int         shadow_count;
    logic [7:0] staged_chars [N_CHARS];
    int         staged_len;

    stws_pkg::t_rsp rsp_q[$];
    t_row           dir_rows[$];
    int             n_bad;
    int             n_seen;
    bit             stim_done;

    string_table_with_sort_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // True when entry a sorts strictly after entry b.
    function automatic bit sorts_after(int a, int b);
        int n;
        n = (shadow_len[a] < shadow_len[b]) ? shadow_len[a] : shadow_len[b];
        for (int i = 0; i < n; i++) begin
            if (shadow_chars[a][i] != shadow_chars[b][i])
                return shadow_chars[a][i] > shadow_chars[b][i];
        end
        return shadow_len[a] > shadow_len[b];
    endfunction

    // Applies one item to the shadow table and returns the result it gives.
    task automatic apply_item(input stws_pkg::t_item it, output stws_pkg::t_rsp r);
        int         idx;
        int         pos;
        int         tl;
        logic [7:0] tc;
        r = '0;
        idx = int'(it.entry_index);
        pos = int'(it.char_pos);
        r.status = stws_pkg::STATUS_OK;
        case (it.func)
            stws_pkg::FUNC_APPEND: begin
                if (staged_len < N_CHARS) begin
                    staged_chars[staged_len] = it.char_in;
                    staged_len++;
                end
                if (it.end_of_string) begin
                    if (shadow_count >= N_ENTRIES) begin
                        r.status = stws_pkg::STATUS_FULL;
                    end else begin
                        for (int i = 0; i < N_CHARS; i++)
                            shadow_chars[shadow_count][i] = staged_chars[i];
                        shadow_len[shadow_count] = staged_len;
                        shadow_count++;
                    end
                    staged_len = 0;
                end
            end
            stws_pkg::FUNC_DELETE: begin
                if (idx == 0 || idx > shadow_count) begin
                    r.status = stws_pkg::STATUS_RANGE;
                end else begin
                    for (int i = idx - 1; i + 1 < shadow_count; i++) begin
                        shadow_chars[i] = shadow_chars[i + 1];
                        shadow_len[i]   = shadow_len[i + 1];
                    end
                    shadow_count--;
                end
            end
            stws_pkg::FUNC_SORT: begin
                for (int i = 0; i + 1 < shadow_count; i++) begin
                    for (int j = 0; j + 1 < shadow_count - i; j++) begin
                        if (sorts_after(j, j + 1)) begin
                            for (int k = 0; k < N_CHARS; k++) begin
                                tc = shadow_chars[j][k];
                                shadow_chars[j][k] = shadow_chars[j + 1][k];
                                shadow_chars[j + 1][k] = tc;
                            end
                            tl = shadow_len[j];
                            shadow_len[j] = shadow_len[j + 1];
                            shadow_len[j + 1] = tl;
                        end
                    end
                end
            end
            default: begin
                if (idx == 0 || idx > shadow_count)
                    r.status = stws_pkg::STATUS_RANGE;
                else if (pos < shadow_len[idx - 1] && pos < N_CHARS)
                    r.char_out = shadow_chars[idx - 1][pos];
            end
        endcase
        r.entry_count = shadow_count[CW-1:0];
    endtask

    function automatic stws_pkg::t_item make_item(stws_pkg::t_func f, logic [7:0] ch,
                                                  logic eos, logic [4:0] idx,
                                                  logic [4:0] pos);
        stws_pkg::t_item it;
        it.func          = f;
        it.char_in       = ch;
        it.end_of_string = eos;
        it.entry_index   = idx;
        it.char_pos      = pos;
        return it;
    endfunction

    task automatic add_row(stws_pkg::t_item it, bit known, logic [7:0] ch, int cnt,
                           logic [1:0] st);
        t_row row;
        row.it               = it;
        row.known            = known;
        row.rsp.char_out     = ch;
        row.rsp.entry_count  = cnt[CW-1:0];
        row.rsp.status       = st;
        dir_rows.push_back(row);
    endtask

    // Offers one beat after a random gap and records its result once accepted.
    task automatic send_item(stws_pkg::t_item it, bit known, stws_pkg::t_rsp typed);
        int             r;
        int             gap;
        stws_pkg::t_rsp pred;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.char_pos, it.entry_index, it.char_in};
        s_axis_tuser  <= it.func;
        s_axis_tlast  <= it.end_of_string;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_item(it, pred);
        rsp_q.push_back(known ? typed : pred);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return 8'(8'h61 + $urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [4:0] pick_index();
        if (shadow_count > 0 && $urandom_range(0, 9) != 0)
            return 5'($urandom_range(1, shadow_count));
        return 5'($urandom_range(0, 31));
    endfunction

    // Stimulus: the directed table first, then random items in phases that
    // alternately fill and drain the table.
    initial begin
        stws_pkg::t_item it;
        stws_pkg::t_rsp  none;
        int              r;
        int              target;
        int              del_pct;
        none = '0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stws_pkg::FUNC_APPEND;
        s_axis_tlast  = 1'b0;
        stim_done     = 1'b0;
        shadow_count  = 0;
        staged_len    = 0;
        for (int i = 0; i < N_ENTRIES; i++) shadow_len[i] = 0;

        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd1,  5'd0),
                1'b1, 8'h00, 0, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_DELETE, 8'h00, 1'b0, 5'd1,  5'd0),
                1'b1, 8'h00, 0, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_SORT,   8'h00, 1'b0, 5'd0,  5'd0),
                1'b1, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_APPEND, 8'hFF, 1'b0, 5'd31, 5'd31),
                1'b1, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_APPEND, 8'h00, 1'b1, 5'd0,  5'd0),
                1'b1, 8'h00, 1, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_APPEND, 8'h41, 1'b1, 5'd0,  5'd0),
                1'b1, 8'h00, 2, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'hFF, 1'b1, 5'd1,  5'd0),
                1'b1, 8'hFF, 2, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd1,  5'd1),
                1'b1, 8'h00, 2, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd1,  5'd31),
                1'b1, 8'h00, 2, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd0,  5'd0),
                1'b1, 8'h00, 2, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd31, 5'd0),
                1'b1, 8'h00, 2, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_SORT,   8'hFF, 1'b1, 5'd31, 5'd31),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd1,  5'd0),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd2,  5'd0),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        // A new entry of a single zero byte, which sorts before the others.
        add_row(make_item(stws_pkg::FUNC_APPEND, 8'h00, 1'b1, 5'd0,  5'd0),
                1'b1, 8'h00, 3, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_SORT,   8'h00, 1'b0, 5'd0,  5'd0),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd1,  5'd0),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd2,  5'd1),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_DELETE, 8'h00, 1'b0, 5'd4,  5'd0),
                1'b1, 8'h00, 3, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_DELETE, 8'h00, 1'b0, 5'd0,  5'd0),
                1'b1, 8'h00, 3, stws_pkg::STATUS_RANGE);
        add_row(make_item(stws_pkg::FUNC_DELETE, 8'h00, 1'b0, 5'd2,  5'd0),
                1'b1, 8'h00, 2, stws_pkg::STATUS_OK);
        add_row(make_item(stws_pkg::FUNC_READ,   8'h00, 1'b0, 5'd2,  5'd0),
                1'b0, 8'h00, 0, stws_pkg::STATUS_OK);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].known, dir_rows[k].rsp);

        target  = 1;
        del_pct = 3;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) del_pct = (del_pct == 3) ? 25 : 3;
            if (staged_len == 0)
                target = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 5)
                                                      : $urandom_range(18, 24);
            r = $urandom_range(0, 99);
            it = make_item(stws_pkg::FUNC_APPEND, pick_char(), 1'($urandom_range(0, 1)),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            if (r < 55) begin
                it.end_of_string = (staged_len + 1 >= target);
            end else if (r < 97 - del_pct) begin
                it.func        = stws_pkg::FUNC_READ;
                it.entry_index = pick_index();
                if ($urandom_range(0, 3) != 0) it.char_pos = 5'($urandom_range(0, 6));
            end else if (r < 97) begin
                it.func        = stws_pkg::FUNC_DELETE;
                it.entry_index = pick_index();
            end else begin
                it.func = stws_pkg::FUNC_SORT;
            end
            send_item(it, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver readiness: random stalls, one long hold-off while the sender keeps offering.
    initial begin
        int  stall_left;
        int  r;
        bit  held;
        stall_left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!held && n_seen >= 300) begin
                held = 1'b1;
                stall_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else if (r < 17) begin
                    stall_left = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Result checking against the oldest expectation.
    initial begin
        n_bad  = 0;
        n_seen = 0;
    end

    always @(posedge i_clk) begin
        stws_pkg::t_rsp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_seen++;
            if (rsp_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result beat: data %h status %h",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                want = rsp_q.pop_front();
                if (m_axis_tdata[7:0] !== want.char_out ||
                    m_axis_tdata[12:8] !== want.entry_count ||
                    m_axis_tdata[15:13] !== 3'b0 ||
                    m_axis_tuser !== want.status) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display({"result %0d: expected char %h count %0d status %0d, ",
                                  "got char %h count %0d status %0d"},
                                 n_seen, want.char_out, want.entry_count, want.status,
                                 m_axis_tdata[7:0], m_axis_tdata[12:8], m_axis_tuser);
                end
            end
        end
    end

    // End of run.
    initial begin
        wait (stim_done);
        while (rsp_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_bad == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog.
    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/stws_pkg.sv
design/stws_ram.sv
design/stws_ctrl.sv
design/string_table_with_sort_core.sv
bench/tb.sv
